// ----- rtl/ksel_pkg.sv -----
// ksel_pkg: shared constants and controller/datapath command and status types
// for the k-smallest selector. Depends on nothing.
package ksel_pkg;

  localparam int DEF_MAX_K       = 16;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int CFG_WIDTH       = 5;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(1);

  // Controller to datapath
  typedef struct packed {
    logic insert;    // insert the accepted word into the sorted chain
    logic pop_load;  // move the head of the chain into the output register
    logic err_load;  // load the too-few error word into the output register
    logic clear;     // empty the chain for the next set
  } ksel_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic too_few;   // set held fewer values than the selected count
    logic last_word; // next popped word is the final one of the set
  } ksel_sts_t;

endpackage

// ----- rtl/ksel_in_if.sv -----
// ksel_in_if: valid/ready channel carrying one input word of a set.
// Depends on nothing.
interface ksel_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic                          end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

// ----- rtl/ksel_out_if.sv -----
// ksel_out_if: valid/ready channel carrying one result word.
// Depends on nothing.
interface ksel_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic                          last_result;
  logic                          too_few;

  modport source (output valid, output result_value, output last_result, output too_few,
                  input ready);
  modport sink   (input valid, input result_value, input last_result, input too_few,
                  output ready);
endinterface

// ----- rtl/k_smallest_selector.sv -----
// k_smallest_selector: top level of the streaming k-smallest selector.
// Depends on ksel_pkg, ksel_in_if, ksel_out_if, ksel_ctrl and ksel_dp.
//
// Usage
//   in_ch   : one word per value of a set; end_of_set marks the final one.
//             While a set is collected, in_ch.ready is high and one word is
//             taken every cycle: a chain of MAX_K compare-and-shift cells
//             keeps the smallest values in ascending order.
//   out_ch  : after the last word of a set, the select_count smallest values
//             come out in ascending order, last_result on the final one.
//             A set shorter than select_count gives one word with
//             result_value 0, last_result 1 and too_few 1.
//   cfg_*   : cfg_wr_en writes cfg_wr_data to select_count (clamped to
//             1..MAX_K). Write it only between sets.
// Flow
//   After the end word is taken, the controller enters its emit state and
//   loads the first result into the output register once that register is
//   free; then one result per cycle while out_ch.ready is high. in_ch.ready
//   drops from the cycle after the end word until the last result is loaded.
// Reset
//   Synchronous, active low: chain emptied, select_count back to 1,
//   no result pending, in_ch.ready high.
// Stall
//   A stalled result holds in the output register; emission waits, but the
//   next set starts streaming as soon as the last result is loaded.
module k_smallest_selector
  import ksel_pkg::*;
#(
  parameter int MAX_K       = DEF_MAX_K,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ksel_in_if.sink              in_ch,
  ksel_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data
);

  ksel_cmd_t cmd;
  ksel_sts_t sts;

  // sequencing: collect words, then drain the chain head one word at a time
  ksel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_end    (in_ch.end_of_set),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // sorted chain plus output payload register
  ksel_dp #(
    .MAX_K       (MAX_K),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_ch.sample_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_value   (out_ch.result_value),
    .out_last    (out_ch.last_result),
    .out_too_few (out_ch.too_few)
  );

  // the error word always closes its set
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.too_few) |-> out_ch.last_result)
    else $error("too_few word without last_result");

  // taking the end word stops intake for the emit phase
  a_end_stops_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.end_of_set) |=> !in_ch.ready)
    else $error("intake still open after end of set");

  // intake reopens only once the final result of the set is loaded
  a_reopen_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ch.ready) |-> (out_ch.valid && out_ch.last_result))
    else $error("intake reopened before final result");

  // never insert and load the output register at once, nor pop and error-load at once
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.pop_load, cmd.err_load}))
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/ksel_ctrl.sv -----
// ksel_ctrl: collect/emit state machine and output-register valid flag.
// Depends on ksel_pkg.
module ksel_ctrl
  import ksel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_end,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ksel_sts_t sts,
  output ksel_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        can_load;
  logic        accept;

  assign in_ready  = (state_r == ST_COLLECT);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  // output register is free or empties this cycle
  assign can_load  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_COLLECT: begin
        cmd.insert = accept;
        if (accept && in_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          if (sts.too_few) begin
            cmd.err_load = 1'b1;
            cmd.clear    = 1'b1;
            state_nxt    = ST_COLLECT;
          end else begin
            cmd.pop_load = 1'b1;
            if (sts.last_word) begin
              cmd.clear = 1'b1;
              state_nxt = ST_COLLECT;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ksel_dp.sv -----
// ksel_dp: sorted compare-and-shift chain, fill count, emit counter,
// select-count register and output payload register. Depends on ksel_pkg.
module ksel_dp
  import ksel_pkg::*;
#(
  parameter int MAX_K       = DEF_MAX_K,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_WIDTH-1:0]          cfg_wr_data,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  ksel_cmd_t                     cmd,
  output ksel_sts_t                     sts,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_last,
  output logic                          out_too_few
);

  localparam int CW = $clog2(MAX_K + 1);

  logic signed [VALUE_WIDTH-1:0] cell_r [MAX_K];
  logic signed [VALUE_WIDTH-1:0] cell_nxt [MAX_K];
  logic [MAX_K-1:0]              gt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [CFG_WIDTH-1:0]          cfg_r;
  logic [CW-1:0]                 k_eff;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic                          out_last_r;
  logic                          out_too_few_r;

  // clamp the select count into 1..MAX_K
  always_comb begin
    if (cfg_r == '0) begin
      k_eff = CW'(1);
    end else if (32'(cfg_r) > MAX_K) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(cfg_r);
    end
  end

  assign sts.too_few   = (idx_r == '0) && (count_r < k_eff);
  assign sts.last_word = ((idx_r + CW'(1)) == k_eff);

  // Empty cells compare as larger than anything, so the new word lands
  // at the first cell that is empty or holds a strictly larger value.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign gt[i] = !(CW'(i) < count_r) || (cell_r[i] > in_value);

    if (i == 0) begin : g_head
      always_comb begin
        cell_nxt[i] = cell_r[i];
        if (cmd.insert) begin
          if (gt[i]) cell_nxt[i] = in_value;
        end else if (cmd.pop_load) begin
          if (MAX_K > 1) cell_nxt[i] = cell_r[(MAX_K > 1) ? i + 1 : i];
        end
      end
    end else begin : g_body
      always_comb begin
        cell_nxt[i] = cell_r[i];
        if (cmd.insert) begin
          if (gt[i]) cell_nxt[i] = gt[i-1] ? cell_r[i-1] : in_value;
        end else if (cmd.pop_load) begin
          if (i < MAX_K - 1) cell_nxt[i] = cell_r[(i < MAX_K - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.clear) begin
      count_nxt = '0;
      idx_nxt   = '0;
    end else begin
      if (cmd.insert && (count_r < CW'(MAX_K))) count_nxt = count_r + CW'(1);
      if (cmd.pop_load) idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      cfg_r   <= CFG_RESET;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_K; j++) begin
      cell_r[j] <= cell_nxt[j];
    end
    if (cmd.err_load) begin
      out_value_r   <= '0;
      out_last_r    <= 1'b1;
      out_too_few_r <= 1'b1;
    end else if (cmd.pop_load) begin
      out_value_r   <= cell_r[0];
      out_last_r    <= sts.last_word;
      out_too_few_r <= 1'b0;
    end
  end

  assign out_value   = out_value_r;
  assign out_last    = out_last_r;
  assign out_too_few = out_too_few_r;

endmodule
